// ===== sv/bhbm_pkg.sv =====
package bhbm_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int COUNT_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int TOT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 6;
    localparam int KIND_W     = 2;

    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_ADD   = 2'd0;
    localparam t_kind KIND_CLEAR = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    localparam logic [CFG_W-1:0] MIN_BLOCK_RESET = 6'd4;

    typedef struct packed {
        logic [COUNT_BITS-1:0] ones;
        logic [COUNT_BITS-1:0] size;
    } t_blk;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_DOWN,
        SH_UP
    } t_shift;

    typedef struct packed {
        t_shift           shift;
        logic             inject;
        logic [IDX_W-1:0] inject_idx;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        MG_IDLE,
        MG_START,
        MG_STEP,
        MG_FLUSH
    } t_merge_cmd;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== sv/bhbm_cell.sv =====
module bhbm_cell import bhbm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  t_blk             i_from_up,
    input  t_blk             i_from_dn,
    input  t_blk             i_inject,
    output t_blk             o_blk
);

    t_blk r_blk;
    t_blk n_blk;

    always_comb begin
        case (i_ctl.shift)
            SH_HOLD: n_blk = r_blk;
            SH_DOWN: n_blk = i_from_up;
            SH_UP:   n_blk = i_from_dn;
            default: n_blk = r_blk;
        endcase
        // an injected block wins over the neighbor transfer
        if (i_ctl.inject && (i_ctl.inject_idx == i_idx)) begin
            n_blk = i_inject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
        end else begin
            r_blk <= n_blk;
        end
    end

    assign o_blk = r_blk;

endmodule

// ===== sv/bhbm_merge.sv =====
module bhbm_merge import bhbm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_merge_cmd       i_cmd,
    input  t_blk             i_head,
    output t_blk             o_cur,
    output logic             o_emit,
    output logic [TOT_W-1:0] o_merges
);

    t_blk             r_cur;
    t_blk             n_cur;
    logic             r_seen;
    logic             n_seen;
    logic [TOT_W-1:0] r_merges;
    logic [TOT_W-1:0] n_merges;
    logic             w_eq;
    logic             w_merge;

    assign w_eq    = (r_cur.size == i_head.size);
    assign w_merge = (i_cmd == MG_STEP) && w_eq && r_seen;
    assign o_emit  = ((i_cmd == MG_STEP) && !w_merge) || (i_cmd == MG_FLUSH);

    always_comb begin
        n_cur    = r_cur;
        n_seen   = r_seen;
        n_merges = r_merges;
        case (i_cmd)
            MG_START: begin
                n_cur    = i_head;
                n_seen   = 1'b0;
                n_merges = '0;
            end
            MG_STEP: begin
                if (w_merge) begin
                    // fold the older block into the current one, keep walking from it
                    n_cur.ones = sat_add(r_cur.ones, i_head.ones);
                    n_cur.size = sat_add(r_cur.size, i_head.size);
                    n_seen     = 1'b0;
                    n_merges   = r_merges + TOT_W'(1);
                end else begin
                    if (w_eq) begin
                        n_seen = 1'b1;
                    end
                    n_cur = i_head;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_merges <= '0;
        end else begin
            r_seen   <= n_seen;
            r_merges <= n_merges;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    assign o_cur    = r_cur;
    assign o_merges = r_merges;

endmodule

// ===== sv/bit_history_block_merger_core.sv =====
// Bit history block merger: keeps a bit stream as a list of blocks, newest first, in a
// shift chain of 64 cells. A command is taken when start is high and busy is low. An add
// that fills the newest block, a clear, or an add dropped on a full store leaves busy low.
// An add that pushes a new block holds busy through a load state and a consolidation walk
// over all N blocks, N being the block count after the push (at most 64); the walk shifts
// the chain one cell per cycle past a single compare-and-merge unit. A read holds busy as
// it streams one block per cycle, newest first, from the output registers; o_valid marks
// each result for exactly one cycle and the receiver must take it then, there is no stall.
// The last result of a read carries o_last_block. min_block_size sits at byte address 0.
module bit_history_block_merger_core import bhbm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_bit_value,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_ones_count,
    output logic [OUT_W-1:0]  o_zeros_count,
    output logic [OUT_W-1:0]  o_block_size,
    output logic              o_last_block,
    output logic              o_overflowed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MERGE,
        ST_READ
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_min;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] r_t;
    logic             r_ovf;

    t_chain_ctl       w_ctl;
    t_blk             w_inject;
    t_blk             w_push;
    t_blk             w_blk [MAX_BLOCKS];
    t_blk             w_head;
    t_merge_cmd       w_cmd;
    t_blk             w_cur;
    logic             w_emit;
    logic [TOT_W-1:0] w_merges;
    logic             w_fits;
    logic             w_full;
    logic [COUNT_BITS-1:0] w_zeros;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, r_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_BLOCK_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_min <= pwdata[CFG_W-1:0];
        end
    end

    // cell chain, position zero holds the newest block
    assign w_head = w_blk[0];
    assign w_push = '{ones: COUNT_BITS'(i_bit_value), size: COUNT_BITS'(1)};

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        t_blk w_up;
        t_blk w_dn;
        if (g == MAX_BLOCKS - 1) begin : g_top
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = w_blk[g+1];
        end
        if (g == 0) begin : g_first
            assign w_dn = w_push;
        end else begin : g_rest
            assign w_dn = w_blk[g-1];
        end
        bhbm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_idx     (IDX_W'(g)),
            .i_from_up (w_up),
            .i_from_dn (w_dn),
            .i_inject  (w_inject),
            .o_blk     (w_blk[g])
        );
    end

    bhbm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_head   (w_head),
        .o_cur    (w_cur),
        .o_emit   (w_emit),
        .o_merges (w_merges)
    );

    assign busy    = (r_state != ST_IDLE);
    assign w_fits  = (w_head.size < COUNT_BITS'(r_min));
    assign w_full  = (r_total == TOT_W'(MAX_BLOCKS));
    assign w_zeros = (w_head.size >= w_head.ones) ? (w_head.size - w_head.ones) : '0;

    always_comb begin
        w_ctl.shift      = SH_HOLD;
        w_ctl.inject     = 1'b0;
        w_ctl.inject_idx = '0;
        w_inject         = '0;
        w_cmd            = MG_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_ADD: begin
                            if (w_fits) begin
                                w_ctl.inject  = 1'b1;
                                w_inject.ones = sat_add(w_head.ones, COUNT_BITS'(i_bit_value));
                                w_inject.size = sat_add(w_head.size, COUNT_BITS'(1));
                            end else if (!w_full) begin
                                w_ctl.shift = SH_UP;
                            end
                        end
                        KIND_CLEAR: begin
                            w_ctl.inject = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                w_cmd       = MG_START;
                w_ctl.shift = SH_DOWN;
            end
            ST_MERGE: begin
                w_cmd            = (r_t == r_total) ? MG_FLUSH : MG_STEP;
                w_ctl.shift      = SH_DOWN;
                // kept blocks land right behind the ones already written back
                w_ctl.inject     = w_emit;
                w_ctl.inject_idx = IDX_W'(r_total - TOT_W'(1) - w_merges);
                w_inject         = w_cur;
            end
            ST_READ: begin
                // rotate the list once so it is intact after the read
                w_ctl.shift      = SH_DOWN;
                w_ctl.inject     = 1'b1;
                w_ctl.inject_idx = IDX_W'(r_total - TOT_W'(1));
                w_inject         = w_head;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_total       <= TOT_W'(1);
            r_t           <= '0;
            r_ovf         <= 1'b0;
            o_valid       <= 1'b0;
            o_last_block  <= 1'b0;
            o_ones_count  <= '0;
            o_zeros_count <= '0;
            o_block_size  <= '0;
            o_overflowed  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        case (i_kind)
                            KIND_ADD: begin
                                if (!w_fits) begin
                                    if (w_full) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_total <= r_total + TOT_W'(1);
                                        r_state <= ST_LOAD;
                                    end
                                end
                            end
                            KIND_CLEAR: begin
                                r_total <= TOT_W'(1);
                            end
                            KIND_READ: begin
                                r_t     <= '0;
                                r_state <= ST_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    r_t     <= TOT_W'(1);
                    r_state <= ST_MERGE;
                end
                ST_MERGE: begin
                    if (r_t == r_total) begin
                        r_total <= r_total - w_merges;
                        r_state <= ST_IDLE;
                    end else begin
                        r_t <= r_t + TOT_W'(1);
                    end
                end
                ST_READ: begin
                    o_valid       <= 1'b1;
                    o_last_block  <= (r_t == r_total - TOT_W'(1));
                    o_ones_count  <= OUT_W'(w_head.ones);
                    o_zeros_count <= OUT_W'(w_zeros);
                    o_block_size  <= OUT_W'(w_head.size);
                    o_overflowed  <= r_ovf;
                    if (r_t == r_total - TOT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_t <= r_t + TOT_W'(1);
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bhbm_pkg::*;

    localparam t_kind            KIND_NONE          = 2'd3;
    localparam logic [2:0]       REG_MIN_BLOCK_SIZE = 3'd0;
    localparam int               SETTLE_CYCLES      = 80;

    typedef struct packed {
        t_kind kind;
        logic  bit_value;
    } hist_cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] ones;
        logic [OUT_W-1:0] zeros;
        logic [OUT_W-1:0] size;
        logic             is_oldest;
        logic             ovf;
    } blk_rec_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic              i_bit_value = 1'b0;
    logic              o_valid;
    logic [OUT_W-1:0]  o_ones_count;
    logic [OUT_W-1:0]  o_zeros_count;
    logic [OUT_W-1:0]  o_block_size;
    logic              o_last_block;
    logic              o_overflowed;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    bit_history_block_merger_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_bit_value   (i_bit_value),
        .o_valid       (o_valid),
        .o_ones_count  (o_ones_count),
        .o_zeros_count (o_zeros_count),
        .o_block_size  (o_block_size),
        .o_last_block  (o_last_block),
        .o_overflowed  (o_overflowed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // history model
    logic [COUNT_BITS-1:0] hist_ones [MAX_BLOCKS];
    logic [COUNT_BITS-1:0] hist_size [MAX_BLOCKS];
    int                    hist_count;
    logic                  hist_overflow;
    logic [CFG_W-1:0]      fill_limit;

    hist_cmd_t cmd_q [$];
    blk_rec_t  blk_expect_q [$];
    hist_cmd_t nxt_cmd;
    logic      took = 1'b0;
    int        burst_left = 4;
    int        idle_left = 0;
    int        n_errors = 0;
    int        n_taken = 0;
    int        n_blocks = 0;
    int        peak_count = 1;

    function automatic logic [COUNT_BITS-1:0] capped_sum(input logic [COUNT_BITS-1:0] a,
                                                         input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_BITS])
            return {COUNT_BITS{1'b1}};
        return s[COUNT_BITS-1:0];
    endfunction

    function automatic void wipe_history();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            hist_ones[k] = '0;
            hist_size[k] = '0;
        end
        hist_count = 1;
    endfunction

    // Walk newest to oldest; the first equal pair only arms, the next one merges.
    function automatic void merge_pass();
        int i;
        bit armed;
        i = hist_count - 1;
        armed = 1'b0;
        while (i > 0) begin
            if (hist_size[i] == hist_size[i-1]) begin
                if (armed) begin
                    hist_ones[i-1] = capped_sum(hist_ones[i], hist_ones[i-1]);
                    hist_size[i-1] = capped_sum(hist_size[i], hist_size[i-1]);
                    for (int j = i; j + 1 < hist_count; j++) begin
                        hist_ones[j] = hist_ones[j+1];
                        hist_size[j] = hist_size[j+1];
                    end
                    hist_count--;
                    armed = 1'b0;
                end else begin
                    armed = 1'b1;
                end
            end
            i--;
        end
    endfunction

    function automatic void run_cmd(input t_kind kind, input logic bit_value);
        int top;
        int idx;
        blk_rec_t r;
        case (kind)
            KIND_ADD: begin
                top = hist_count - 1;
                if (hist_size[top] < fill_limit) begin
                    hist_size[top] = capped_sum(hist_size[top], COUNT_BITS'(1));
                    hist_ones[top] = capped_sum(hist_ones[top], COUNT_BITS'(bit_value));
                end else if (hist_count >= MAX_BLOCKS) begin
                    hist_overflow = 1'b1;
                end else begin
                    hist_ones[hist_count] = COUNT_BITS'(bit_value);
                    hist_size[hist_count] = COUNT_BITS'(1);
                    hist_count++;
                    if (hist_count > peak_count)
                        peak_count = hist_count;
                    merge_pass();
                end
            end
            KIND_CLEAR: wipe_history();
            KIND_READ: begin
                for (int k = 0; k < hist_count; k++) begin
                    idx = hist_count - 1 - k;
                    r.ones = hist_ones[idx][OUT_W-1:0];
                    r.size = hist_size[idx][OUT_W-1:0];
                    r.zeros = (hist_size[idx] >= hist_ones[idx]) ?
                              OUT_W'(hist_size[idx] - hist_ones[idx]) : '0;
                    r.is_oldest = (idx == 0);
                    r.ovf = hist_overflow;
                    blk_expect_q = {blk_expect_q, r};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    task automatic check_block();
        blk_rec_t e;
        if (blk_expect_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected block ones=%0d size=%0d",
                                    o_ones_count, o_block_size));
            return;
        end
        e = blk_expect_q.pop_front();
        if (o_ones_count !== e.ones)
            flag_mismatch($sformatf("ones_count %0d, want %0d", o_ones_count, e.ones));
        if (o_zeros_count !== e.zeros)
            flag_mismatch($sformatf("zeros_count %0d, want %0d", o_zeros_count, e.zeros));
        if (o_block_size !== e.size)
            flag_mismatch($sformatf("block_size %0d, want %0d", o_block_size, e.size));
        if (o_last_block !== e.is_oldest)
            flag_mismatch($sformatf("last_block %b, want %b", o_last_block, e.is_oldest));
        if (o_overflowed !== e.ovf)
            flag_mismatch($sformatf("overflowed %b, want %b", o_overflowed, e.ovf));
        n_blocks++;
    endtask

    // monitor: predict on each command transfer, check each result strobe
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                run_cmd(t_kind'(i_kind), i_bit_value);
                n_taken++;
            end
            if (o_valid)
                check_block();
        end
    end

    // driver: bursts of commands with random gaps between them
    always @(negedge i_clk) begin
        if (!start || took) begin
            if (i_rst_n && idle_left == 0 && cmd_q.size() > 0) begin
                nxt_cmd = cmd_q.pop_front();
                start <= 1'b1;
                i_kind <= nxt_cmd.kind;
                i_bit_value <= nxt_cmd.bit_value;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    if ($urandom_range(0, 9) == 0)
                        idle_left <= $urandom_range(1, 80);
                    else if ($urandom_range(0, 2) == 0)
                        idle_left <= 0;
                    else
                        idle_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
                i_kind <= KIND_W'($urandom_range(0, 3));
                i_bit_value <= 1'($urandom_range(0, 1));
                if (idle_left > 0)
                    idle_left <= idle_left - 1;
            end
        end
    end

    task automatic queue_cmd(input t_kind kind, input logic bit_value);
        hist_cmd_t c;
        c.kind = kind;
        c.bit_value = bit_value;
        cmd_q = {cmd_q, c};
    endtask

    // Wait for every queued command and every expected block, then let the block go idle.
    task automatic settle();
        @(posedge i_clk);
        while (cmd_q.size() != 0 || start || blk_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_read(output logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_MIN_BLOCK_SIZE;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        val = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_min(input logic [CFG_W-1:0] val);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MIN_BLOCK_SIZE;
        pwdata <= {junk[31:CFG_W], val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        fill_limit = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_read(rd);
        if (rd[CFG_W-1:0] !== fill_limit)
            flag_mismatch($sformatf("min_block_size reads %0d, want %0d",
                                    rd[CFG_W-1:0], fill_limit));
    endtask

    initial begin
        logic [31:0] rd;
        logic [CFG_W-1:0] min_plan [7];
        int r;
        t_kind k;

        wipe_history();
        hist_overflow = 1'b0;
        fill_limit = MIN_BLOCK_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_read(rd);
        if (rd[CFG_W-1:0] !== MIN_BLOCK_RESET)
            flag_mismatch($sformatf("min_block_size after reset %0d", rd[CFG_W-1:0]));

        // directed: empty read, fill to the minimum, pushes, an equal pair that does not merge, unused kind, clear
        queue_cmd(KIND_READ, 1'b1);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_ADD, 1'b0);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_READ, 1'b0);
        queue_cmd(KIND_ADD, 1'b0);
        queue_cmd(KIND_ADD, 1'b0);
        queue_cmd(KIND_ADD, 1'b0);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_ADD, 1'b0);
        queue_cmd(KIND_READ, 1'b1);
        queue_cmd(KIND_NONE, 1'b1);
        queue_cmd(KIND_NONE, 1'b0);
        queue_cmd(KIND_READ, 1'b0);
        queue_cmd(KIND_CLEAR, 1'b1);
        queue_cmd(KIND_READ, 1'b1);
        queue_cmd(KIND_ADD, 1'b1);
        queue_cmd(KIND_CLEAR, 1'b0);
        queue_cmd(KIND_READ, 1'b0);
        settle();

        // random phases across several minimum sizes, extremes included
        min_plan[0] = CFG_W'(0);
        min_plan[1] = CFG_W'(63);
        min_plan[2] = CFG_W'(1);
        min_plan[3] = CFG_W'(2);
        min_plan[4] = CFG_W'($urandom_range(3, 10));
        min_plan[5] = MIN_BLOCK_RESET;
        min_plan[6] = CFG_W'($urandom_range(0, 63));
        for (int p = 0; p < 7; p++) begin
            set_min(min_plan[p]);
            for (int n = 0; n < 45; n++) begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    k = KIND_ADD;
                else if (r < 85)
                    k = KIND_READ;
                else if (r < 92)
                    k = KIND_CLEAR;
                else
                    k = KIND_NONE;
                queue_cmd(k, 1'($urandom_range(0, 1)));
            end
            queue_cmd(KIND_READ, 1'($urandom_range(0, 1)));
            settle();
        end

        // Fill the store with blocks of one and two bits in turn so nothing merges,
        // then overflow it.
        queue_cmd(KIND_CLEAR, 1'($urandom_range(0, 1)));
        settle();
        set_min(CFG_W'(1));
        queue_cmd(KIND_ADD, 1'($urandom_range(0, 1)));
        for (int b = 1; b < MAX_BLOCKS; b++) begin
            queue_cmd(KIND_ADD, 1'($urandom_range(0, 1)));
            if (b % 16 == 0)
                queue_cmd(KIND_READ, 1'($urandom_range(0, 1)));
            settle();
            if (b % 2 == 1) begin
                // grow the new block to two bits; the next push happens under this limit
                set_min(CFG_W'(2));
                queue_cmd(KIND_ADD, 1'($urandom_range(0, 1)));
                settle();
            end else begin
                set_min(CFG_W'(1));
            end
        end
        set_min(CFG_W'(0));
        for (int n = 0; n < 6; n++)
            queue_cmd(KIND_ADD, 1'($urandom_range(0, 1)));
        queue_cmd(KIND_READ, 1'($urandom_range(0, 1)));
        queue_cmd(KIND_CLEAR, 1'($urandom_range(0, 1)));
        queue_cmd(KIND_READ, 1'($urandom_range(0, 1)));
        for (int n = 0; n < 10; n++)
            queue_cmd(KIND_ADD, 1'($urandom_range(0, 1)));
        queue_cmd(KIND_READ, 1'($urandom_range(0, 1)));
        settle();

        $display("Run took %0d commands and checked %0d blocks read back.", n_taken, n_blocks);
        $display("Deepest history held %0d blocks; store overflow %0s.", peak_count,
                 hist_overflow ? "reached" : "not reached");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Timeout with %0d commands and %0d blocks pending", cmd_q.size(),
                 blk_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
